FILE: hdl/mdiophy_pkg.sv
// Shared types, constants and PHY register decode for the MDIO PHY register model.
package mdiophy_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned PHY_W  = 16;
   localparam int unsigned IDX_W  = 5;

   typedef enum logic [1:0] {
      CMD_WRITE_CONTROL = 2'd0,
      CMD_WRITE_DATA    = 2'd1,
      CMD_READ_DATA     = 2'd2,
      CMD_READ_CONTROL  = 2'd3
   } command_type;

   // PHY register indexes
   localparam logic [IDX_W-1:0] PHY_BMCR   = 5'd0;
   localparam logic [IDX_W-1:0] PHY_BMSR   = 5'd1;
   localparam logic [IDX_W-1:0] PHY_ID1    = 5'd2;
   localparam logic [IDX_W-1:0] PHY_ID2    = 5'd3;
   localparam logic [IDX_W-1:0] PHY_ANAR   = 5'd4;
   localparam logic [IDX_W-1:0] PHY_ANLPAR = 5'd5;
   localparam logic [IDX_W-1:0] PHY_AUX    = 5'd31;

   localparam logic [PHY_W-1:0] DEF_BMCR   = 16'h3100;
   localparam logic [PHY_W-1:0] DEF_BMSR   = 16'h786D;
   localparam logic [PHY_W-1:0] DEF_ID1    = 16'h0040;
   localparam logic [PHY_W-1:0] DEF_ID2    = 16'h61E0;
   localparam logic [PHY_W-1:0] DEF_ANAR   = 16'h01E1;
   localparam logic [PHY_W-1:0] DEF_ANLPAR = 16'h01E1;
   localparam logic [PHY_W-1:0] DEF_AUX    = 16'h000B;

   localparam logic [PHY_W-1:0]  BMCR_SELF_CLEAR = 16'h8000;
   localparam logic [PHY_W-1:0]  AUX_KEEP        = 16'h0080;
   localparam logic [DATA_W-1:0] CTRL_BUSY       = 32'h0000_0800;
   localparam int unsigned       CTRL_WRITE_BIT  = 10;
   localparam logic [IDX_W-1:0]  SELECTED_RESET  = 5'd2;

   typedef struct packed {
      logic             bad;
      logic [PHY_W-1:0] value;
   } phy_lookup_type;

   // Read value of a PHY register given the writable register contents.
   function automatic phy_lookup_type phy_read(
      input logic [IDX_W-1:0] idx,
      input logic [PHY_W-1:0] bmcr,
      input logic [PHY_W-1:0] anar,
      input logic [PHY_W-1:0] aux,
      input logic [2:0]       written
   );
      phy_lookup_type res;
      res.bad   = 1'b0;
      res.value = '0;
      case (idx)
         PHY_BMCR:   res.value = written[0] ? bmcr : DEF_BMCR;
         PHY_BMSR:   res.value = DEF_BMSR;
         PHY_ID1:    res.value = DEF_ID1;
         PHY_ID2:    res.value = DEF_ID2;
         PHY_ANAR:   res.value = written[1] ? anar : DEF_ANAR;
         PHY_ANLPAR: res.value = DEF_ANLPAR;
         PHY_AUX:    res.value = written[2] ? aux : DEF_AUX;
         default:    res.bad = 1'b1;
      endcase
      return res;
   endfunction

endpackage

FILE: hdl/mdiophy_if.sv
// Valid/ready channel interfaces for bus accesses and their results.
interface mdiophy_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    command;
   logic [mdiophy_pkg::DATA_W-1:0] bus_value;

   modport source (output valid, output command, output bus_value, input ready);
   modport sink   (input valid, input command, input bus_value, output ready);
endinterface

interface mdiophy_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mdiophy_pkg::DATA_W-1:0] read_value;
   logic                          unmodelled_error;

   modport source (output valid, output read_value, output unmodelled_error, input ready);
   modport sink   (input valid, input read_value, input unmodelled_error, output ready);
endinterface

FILE: hdl/mdio_phy_register_model.sv
// MDIO management unit with a small emulated Ethernet PHY register file.
//
// req (sink): one bus access per transfer: command selects write control,
//   write data, read data or read control; bus_value is the written word.
// rsp (source): exactly one result per access, in order: read_value (zero
//   for writes) and unmodelled_error.
// Path: a request is taken into an input register, decoded against the
//   register file and its result lands in the output register, which
//   drives rsp.valid.
// Throughput: one access per cycle while rsp.ready stays high, limited only
//   by the single decode stage between the input and output registers; the
//   PHY state is updated at the same edge the result is registered, so
//   back-to-back accesses see each other's effects.
// Stall: when rsp.ready is low the output register holds its result; the
//   input register still takes one more access, then req.ready drops until
//   the output drains.
// Reset (synchronous, active high): both stages empty, PHY registers back to
//   their defaults, selected register index 2, control and data words zero,
//   no data word present.
module mdio_phy_register_model (
   input  logic                 clock,
   input  logic                 reset,
   mdiophy_req_if.sink          req,
   mdiophy_rsp_if.source        rsp
);

   // input stage
   logic                                 s1_valid_ff, s1_valid_in;
   logic [1:0]                           s1_command_ff;
   logic [mdiophy_pkg::DATA_W-1:0]       s1_value_ff;

   // output stage
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [mdiophy_pkg::DATA_W-1:0]       rsp_read_value_ff, rsp_read_value_in;
   logic                                 rsp_error_ff, rsp_error_in;

   // architectural state
   logic [mdiophy_pkg::PHY_W-1:0]        bmcr_ff, bmcr_in;
   logic [mdiophy_pkg::PHY_W-1:0]        anar_ff, anar_in;
   logic [mdiophy_pkg::PHY_W-1:0]        aux_ff, aux_in;
   logic [2:0]                           written_ff, written_in;
   logic [mdiophy_pkg::IDX_W-1:0]        selected_ff, selected_in;
   logic [mdiophy_pkg::DATA_W-1:0]       control_ff, control_in;
   logic [mdiophy_pkg::DATA_W-1:0]       data_word_ff, data_word_in;
   logic                                 data_present_ff, data_present_in;

   logic                                 out_free;
   logic                                 advance;
   logic                                 req_take;
   mdiophy_pkg::command_type             s1_cmd;
   logic [mdiophy_pkg::IDX_W-1:0]        ctl_idx;
   logic                                 ctl_write;
   mdiophy_pkg::phy_lookup_type          ctl_old;
   mdiophy_pkg::phy_lookup_type          ctl_rd;
   mdiophy_pkg::phy_lookup_type          sel_rd;
   logic [mdiophy_pkg::PHY_W-1:0]        wr_value;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign advance   = s1_valid_ff && out_free;
   assign req.ready = !s1_valid_ff || out_free;
   assign req_take  = req.valid && req.ready;
   assign s1_cmd    = mdiophy_pkg::command_type'(s1_command_ff);

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.read_value       = rsp_read_value_ff;
   assign rsp.unmodelled_error = rsp_error_ff;

   // control write decode
   assign ctl_idx   = s1_value_ff[mdiophy_pkg::IDX_W-1:0];
   assign ctl_write = s1_value_ff[mdiophy_pkg::CTRL_WRITE_BIT];
   assign ctl_old   = mdiophy_pkg::phy_read(ctl_idx, bmcr_ff, anar_ff, aux_ff, written_ff);
   assign sel_rd    = mdiophy_pkg::phy_read(selected_ff, bmcr_ff, anar_ff, aux_ff, written_ff);

   // value a PHY write would store at ctl_idx
   always_comb begin
      case (ctl_idx)
         mdiophy_pkg::PHY_BMCR:
            wr_value = data_word_ff[mdiophy_pkg::PHY_W-1:0] & ~mdiophy_pkg::BMCR_SELF_CLEAR;
         mdiophy_pkg::PHY_AUX:
            wr_value = (ctl_old.value & ~mdiophy_pkg::AUX_KEEP)
                     | (data_word_ff[mdiophy_pkg::PHY_W-1:0] & mdiophy_pkg::AUX_KEEP);
         default:
            wr_value = data_word_ff[mdiophy_pkg::PHY_W-1:0];
      endcase
   end

   always_comb begin
      s1_valid_in       = req_take || (s1_valid_ff && !out_free);
      rsp_valid_in      = advance || (rsp_valid_ff && !rsp.ready);
      rsp_read_value_in = rsp_read_value_ff;
      rsp_error_in      = rsp_error_ff;
      bmcr_in           = bmcr_ff;
      anar_in           = anar_ff;
      aux_in            = aux_ff;
      written_in        = written_ff;
      selected_in       = selected_ff;
      control_in        = control_ff;
      data_word_in      = data_word_ff;
      data_present_in   = data_present_ff;
      ctl_rd            = ctl_old;

      // a write to a writable register is read straight back
      if (ctl_write) begin
         case (ctl_idx)
            mdiophy_pkg::PHY_BMCR, mdiophy_pkg::PHY_ANAR, mdiophy_pkg::PHY_AUX: begin
               ctl_rd.bad   = 1'b0;
               ctl_rd.value = wr_value;
            end
            default: ctl_rd = ctl_old;
         endcase
      end

      if (advance) begin
         rsp_read_value_in = '0;
         rsp_error_in      = 1'b0;
         case (s1_cmd)
            mdiophy_pkg::CMD_WRITE_CONTROL: begin
               selected_in = ctl_idx;
               control_in  = s1_value_ff & ~mdiophy_pkg::CTRL_BUSY;
               if (ctl_write) begin
                  case (ctl_idx)
                     mdiophy_pkg::PHY_BMCR: begin
                        bmcr_in       = wr_value;
                        written_in[0] = 1'b1;
                     end
                     mdiophy_pkg::PHY_ANAR: begin
                        anar_in       = wr_value;
                        written_in[1] = 1'b1;
                     end
                     mdiophy_pkg::PHY_AUX: begin
                        aux_in        = wr_value;
                        written_in[2] = 1'b1;
                     end
                     default: ;
                  endcase
               end
               data_word_in    = {{(mdiophy_pkg::DATA_W-mdiophy_pkg::PHY_W){1'b0}},
                                  ctl_rd.value};
               data_present_in = 1'b1;
               rsp_error_in    = ctl_rd.bad;
            end
            mdiophy_pkg::CMD_WRITE_DATA: begin
               data_word_in    = s1_value_ff;
               data_present_in = 1'b1;
            end
            mdiophy_pkg::CMD_READ_DATA: begin
               if (data_present_ff) begin
                  rsp_read_value_in = data_word_ff;
               end else begin
                  rsp_read_value_in = {{(mdiophy_pkg::DATA_W-mdiophy_pkg::PHY_W){1'b0}},
                                       sel_rd.value};
                  rsp_error_in      = sel_rd.bad;
               end
            end
            mdiophy_pkg::CMD_READ_CONTROL: begin
               rsp_read_value_in = control_ff;
            end
            default: ;
         endcase
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         bmcr_ff         <= '0;
         anar_ff         <= '0;
         aux_ff          <= '0;
         written_ff      <= '0;
         selected_ff     <= mdiophy_pkg::SELECTED_RESET;
         control_ff      <= '0;
         data_word_ff    <= '0;
         data_present_ff <= 1'b0;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         bmcr_ff         <= bmcr_in;
         anar_ff         <= anar_in;
         aux_ff          <= aux_in;
         written_ff      <= written_in;
         selected_ff     <= selected_in;
         control_ff      <= control_in;
         data_word_ff    <= data_word_in;
         data_present_ff <= data_present_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_command_ff <= req.command;
         s1_value_ff   <= req.bus_value;
      end
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_error_ff      <= rsp_error_in;
   end

   // a data write always answers zero with no error
   a_write_data_quiet: assert property (@(posedge clock) disable iff (reset)
      advance && s1_cmd == mdiophy_pkg::CMD_WRITE_DATA
      |=> rsp.read_value == '0 && !rsp.unmodelled_error)
      else $error("data write produced nonzero result");

   // any control write leaves a data word present
   a_ctl_sets_present: assert property (@(posedge clock) disable iff (reset)
      advance && s1_cmd == mdiophy_pkg::CMD_WRITE_CONTROL |=> data_present_ff)
      else $error("control write did not load data word");

   // a blocked input stage keeps its access
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_value_ff)
                                   && $stable(s1_command_ff))
      else $error("input stage lost a stalled access");

   // state only moves when an access completes decode
   a_state_quiet: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(written_ff) && $stable(selected_ff) && $stable(control_ff))
      else $error("PHY state changed without an access");

endmodule

FILE: sim/mdio_phy_access_checker.sv
`timescale 1ns / 100ps
// Result predictor and scoreboard that watches the MDIO PHY register model's req and rsp channels.
module mdio_phy_access_checker (
   input  logic   clock,
   input  logic   reset,
   mdiophy_req_if req,
   mdiophy_rsp_if rsp,
   output int     mismatches,
   output int     pending
);
   import mdiophy_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0] read_value;
      logic              unmodelled_error;
   } access_result_t;

   access_result_t expected_q[$];
   int             fault_count = 0;

   // shadow of the emulated PHY and the management registers
   logic [PHY_W-1:0]  phy_store [3];
   logic [2:0]        phy_written;
   logic [IDX_W-1:0]  selected_index;
   logic [DATA_W-1:0] control_word;
   logic [DATA_W-1:0] data_word;
   logic              data_present;

   assign mismatches = fault_count;
   initial pending = 0;

   function automatic logic [PHY_W-1:0] phy_value(input logic [IDX_W-1:0] idx,
                                                  output logic bad);
      bad = 1'b0;
      case (idx)
         PHY_BMCR:   return phy_written[0] ? phy_store[0] : DEF_BMCR;
         PHY_BMSR:   return DEF_BMSR;
         PHY_ID1:    return DEF_ID1;
         PHY_ID2:    return DEF_ID2;
         PHY_ANAR:   return phy_written[1] ? phy_store[1] : DEF_ANAR;
         PHY_ANLPAR: return DEF_ANLPAR;
         PHY_AUX:    return phy_written[2] ? phy_store[2] : DEF_AUX;
         default: begin
            bad = 1'b1;
            return '0;
         end
      endcase
   endfunction

   function automatic void phy_update(input logic [IDX_W-1:0] idx,
                                      input logic [DATA_W-1:0] value, output logic bad);
      logic [PHY_W-1:0] aux_prev;
      logic             unused_bad;
      bad = 1'b0;
      case (idx)
         PHY_BMCR: begin
            phy_store[0]   = value[PHY_W-1:0] & ~BMCR_SELF_CLEAR;
            phy_written[0] = 1'b1;
         end
         PHY_ANAR: begin
            phy_store[1]   = value[PHY_W-1:0];
            phy_written[1] = 1'b1;
         end
         PHY_AUX: begin
            aux_prev       = phy_value(PHY_AUX, unused_bad);
            phy_store[2]   = (aux_prev & ~AUX_KEEP) | (value[PHY_W-1:0] & AUX_KEEP);
            phy_written[2] = 1'b1;
         end
         PHY_BMSR, PHY_ID1, PHY_ID2, PHY_ANLPAR: ;  // read-only, write dropped
         default: bad = 1'b1;
      endcase
   endfunction

   function automatic access_result_t predict_access(input command_type cmd,
                                                     input logic [DATA_W-1:0] value);
      access_result_t   res;
      logic             bad;
      logic [PHY_W-1:0] reg_value;
      res = '0;
      case (cmd)
         CMD_WRITE_CONTROL: begin
            selected_index = value[IDX_W-1:0];
            control_word   = value & ~CTRL_BUSY;
            if (value[CTRL_WRITE_BIT]) begin
               phy_update(selected_index, data_word, bad);
               if (bad) res.unmodelled_error = 1'b1;
            end
            reg_value = phy_value(selected_index, bad);
            if (bad) res.unmodelled_error = 1'b1;
            data_word    = {{(DATA_W-PHY_W){1'b0}}, reg_value};
            data_present = 1'b1;
         end
         CMD_WRITE_DATA: begin
            data_word    = value;
            data_present = 1'b1;
         end
         CMD_READ_DATA: begin
            if (data_present) begin
               res.read_value = data_word;
            end else begin
               reg_value            = phy_value(selected_index, bad);
               res.read_value       = {{(DATA_W-PHY_W){1'b0}}, reg_value};
               res.unmodelled_error = bad;
            end
         end
         default: res.read_value = control_word;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      access_result_t want;
      if (reset) begin
         phy_store      = '{default: '0};
         phy_written    = '0;
         selected_index = SELECTED_RESET;
         control_word   = '0;
         data_word      = '0;
         data_present   = 1'b0;
         expected_q.delete();
      end else begin
         // responses first: a request taken at this edge cannot answer at it
         if (rsp.valid && rsp.ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: result with none expected: read_value=%h error=%b",
                        $time, rsp.read_value, rsp.unmodelled_error);
               fault_count++;
            end else begin
               want = expected_q.pop_front();
               if (want.read_value !== rsp.read_value) begin
                  $display("%0t: read_value expected %h actual %h",
                           $time, want.read_value, rsp.read_value);
                  fault_count++;
               end
               if (want.unmodelled_error !== rsp.unmodelled_error) begin
                  $display("%0t: unmodelled_error expected %b actual %b",
                           $time, want.unmodelled_error, rsp.unmodelled_error);
                  fault_count++;
               end
            end
         end
         if (req.valid && req.ready)
            expected_q.push_back(predict_access(command_type'(req.command), req.bus_value));
      end
      pending <= expected_q.size();
   end

endmodule

FILE: sim/tb_mdio_phy_register_model.sv
`timescale 1ns / 100ps
// Top of the MDIO PHY register model regression: clock, reset, access stimulus and verdict.
module tb_mdio_phy_register_model;
   import mdiophy_pkg::*;

   localparam int RANDOM_ACCESSES = 1700;
   // indexes with no register behind them
   localparam logic [IDX_W-1:0] PHY_UNMAPPED_LOW  = 5'd6;
   localparam logic [IDX_W-1:0] PHY_UNMAPPED_HIGH = 5'd30;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatches;
   int   pending;
   int   accepted_count = 0;
   int   burst_left = 0;
   int   stall_mode = 0;
   int   stall_left = 0;

   mdiophy_req_if req_bus ();
   mdiophy_rsp_if rsp_bus ();

   mdio_phy_register_model dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   mdio_phy_access_checker access_check (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .rsp        (rsp_bus),
      .mismatches (mismatches),
      .pending    (pending)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Result sink: every so often switch to a new back-pressure mode:
   // always ready, mostly ready, mostly stalled, or a fixed 3-of-8 duty cycle.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 200);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0:       rsp_bus.ready = 1'b1;
         1:       rsp_bus.ready = ($urandom_range(0, 3) != 0);
         2:       rsp_bus.ready = ($urandom_range(0, 3) == 0);
         default: rsp_bus.ready = ((stall_left % 8) < 3);
      endcase
   end

   // One access per call. Accesses go out in bursts; between bursts the
   // channel idles for a random gap (sometimes none) with junk on the payload.
   task automatic transfer_access(input command_type cmd, input logic [DATA_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         repeat (gap) begin
            @(negedge clock);
            req_bus.valid     = 1'b0;
            req_bus.command   = 2'($urandom);
            req_bus.bus_value = $urandom;
         end
      end
      burst_left--;
      @(negedge clock);
      req_bus.valid     = 1'b1;
      req_bus.command   = cmd;
      req_bus.bus_value = value;
      do @(posedge clock); while (!req_bus.ready);
      accepted_count++;
   endtask

   // Control word: index in the low bits, write strobe at bit 10, rest as given.
   function automatic logic [DATA_W-1:0] control_access(input logic [DATA_W-1:0] upper_bits,
                                                        input logic do_write,
                                                        input logic [IDX_W-1:0] idx);
      logic [DATA_W-1:0] value;
      value                 = upper_bits;
      value[IDX_W-1:0]      = idx;
      value[CTRL_WRITE_BIT] = do_write;
      return value;
   endfunction

   // Bias toward the writable registers; the fixed ones and the
   // unmapped space still get regular hits.
   function automatic logic [IDX_W-1:0] pick_index();
      case ($urandom_range(0, 9))
         0, 1:    return PHY_BMCR;
         2, 3:    return PHY_ANAR;
         4, 5:    return PHY_AUX;
         6:       return 5'($urandom_range(PHY_BMSR, PHY_ANLPAR));
         7:       return ($urandom_range(0, 1) != 0) ? PHY_ID1 : PHY_ID2;
         default: return 5'($urandom);
      endcase
   endfunction

   initial begin
      // every input known from time zero
      req_bus.valid     = 1'b0;
      req_bus.command   = CMD_WRITE_DATA;
      req_bus.bus_value = '0;
      rsp_bus.ready     = 1'b0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ---- directed accesses ----
      // no data word yet: a data read returns the selected register (index 2)
      transfer_access(CMD_READ_DATA, '1);
      transfer_access(CMD_READ_CONTROL, '1);
      // control register write with all-ones data: self-clear bit drops,
      // busy bit of the control word is cleared
      transfer_access(CMD_WRITE_DATA, '1);
      transfer_access(CMD_WRITE_CONTROL, control_access('1, 1'b1, PHY_BMCR));
      transfer_access(CMD_READ_DATA, '0);
      transfer_access(CMD_READ_CONTROL, '0);
      // aux register keeps only bit 7 of a write: set it, then clear it
      transfer_access(CMD_WRITE_DATA, 32'h0000_FFFF);
      transfer_access(CMD_WRITE_CONTROL, control_access('0, 1'b1, PHY_AUX));
      transfer_access(CMD_READ_DATA, '0);
      transfer_access(CMD_WRITE_DATA, 32'hFFFF_0000);
      transfer_access(CMD_WRITE_CONTROL, control_access('0, 1'b1, PHY_AUX));
      // advertisement register takes the low half of the data word
      transfer_access(CMD_WRITE_DATA, 32'h1234_5678);
      transfer_access(CMD_WRITE_CONTROL, control_access('0, 1'b1, PHY_ANAR));
      // write to a fixed register is dropped
      transfer_access(CMD_WRITE_CONTROL, control_access('0, 1'b1, PHY_BMSR));
      // unmapped index, read only: error, data word goes to zero
      transfer_access(CMD_WRITE_CONTROL, control_access('0, 1'b0, PHY_UNMAPPED_LOW));
      transfer_access(CMD_READ_DATA, '1);
      // unmapped index with the write strobe
      transfer_access(CMD_WRITE_DATA, '1);
      transfer_access(CMD_WRITE_CONTROL, control_access('0, 1'b1, PHY_UNMAPPED_HIGH));
      transfer_access(CMD_WRITE_CONTROL, control_access('0, 1'b0, PHY_ID1));
      transfer_access(CMD_WRITE_CONTROL, control_access('0, 1'b0, PHY_ID2));
      transfer_access(CMD_WRITE_CONTROL, control_access('0, 1'b0, PHY_ANLPAR));
      // write strobe with the data word just refreshed from the last read
      transfer_access(CMD_WRITE_CONTROL, control_access('0, 1'b1, PHY_BMCR));
      transfer_access(CMD_READ_DATA, '0);
      transfer_access(CMD_READ_CONTROL, '0);

      // ---- random accesses ----
      // mostly complete register transactions with random content,
      // the rest single accesses of any command
      accepted_count = 0;
      while (accepted_count < RANDOM_ACCESSES) begin
         if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 3) != 0)
               transfer_access(CMD_WRITE_DATA, $urandom);
            transfer_access(CMD_WRITE_CONTROL,
                            control_access($urandom, ($urandom_range(0, 3) != 0), pick_index()));
            transfer_access(CMD_READ_DATA, $urandom);
            if ($urandom_range(0, 1) != 0)
               transfer_access(CMD_READ_CONTROL, $urandom);
         end else begin
            transfer_access(command_type'(2'($urandom)), $urandom);
         end
      end

      @(negedge clock);
      req_bus.valid = 1'b0;

      // drain, then wait for anything unexpected to surface
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatches == 0)
         $display("mdio_phy_register_model regression: pass");
      else
         $display("mdio_phy_register_model regression: fail");
      $finish;
   end

   // hang guard
   initial begin
      #5_000_000;
      $display("mdio_phy_register_model regression: fail");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/mdiophy_pkg.sv
hdl/mdiophy_if.sv
hdl/mdio_phy_register_model.sv
sim/mdio_phy_access_checker.sv
sim/tb_mdio_phy_register_model.sv
